### design/assert_macros.svh
// Assertion macros shared by the design files.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AST_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define AST_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/apsel_pkg.sv
// Shared types and constants of the aging priority task selector.
// Depends on nothing; imported by apsel_cell and the top level.
package apsel_pkg;

    localparam int SLOT_W     = 3;
    localparam int SLOT_COUNT = 8;
    localparam int RANK_W     = 3;
    localparam int TIME_W     = 32;
    localparam int PRIO_W     = 8;
    localparam int RUNS_W     = 16;
    localparam int OP_W       = 2;
    localparam int ELAPSED_W  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_YIELD  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // Best candidate handed from cell to cell during a yield sweep
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
        logic [PRIO_W-1:0] score;
        logic [RANK_W-1:0] rank;
    } t_scan;

    // Command broadcast to every cell
    typedef struct packed {
        logic              add;
        logic              rem;
        logic              commit;
        logic [SLOT_W-1:0] slot;
        logic              tgt_live;
        logic [RANK_W-1:0] tgt_rank;
        logic [TIME_W-1:0] now;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] period;
        logic [RUNS_W-1:0] runs;
    } t_cmd;

    // Status a cell reports back to the control
    typedef struct packed {
        logic              live;
        logic [RANK_W-1:0] rank;
    } t_cell_stat;

    // Result item, hit in the lowest bit
    typedef struct packed {
        logic [PRIO_W-1:0] score;
        logic [SLOT_W-1:0] chosen;
        logic              hit;
    } t_result;

endpackage

### design/aging_priority_task_selector_top.sv
// Channel   | Dir | Handshake                      | Payload
// request   | in  | i_s_axis_tvalid/o_s_axis_tready | tuser: op; tdata: slot..runs
// result    | out | o_m_axis_tvalid/i_m_axis_tready | tdata: hit, chosen, score
//
// Add, remove and no-op requests finish as soon as they are accepted. A yield
// request sweeps the chain of slot cells: the best candidate ripples down it,
// one cell per cycle, then the winner, if any, is rescheduled.
// Reset (synchronous, active low) frees every slot; stored task fields stay.
// A finished result waits in the output register; a second result waits in a
// hold register, and no request is taken until it has moved out.
//
// Top level of the aging priority task selector; depends on apsel_pkg,
// apsel_cell and assert_macros.svh.
`include "assert_macros.svh"

module aging_priority_task_selector_top
    import apsel_pkg::*;
#(
    parameter int MAX_TASKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // low to high: slot[2:0], now[34:3], base_priority[42:35],
    // period[74:43], runs[90:75], zero pad[95:91]
    input  logic [95:0] i_s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // low to high: hit[0], chosen[3:1], score[11:4], zero pad[15:12]
    output logic [15:0] o_m_axis_tdata
);

    localparam int NCELL = (MAX_TASKS < SLOT_COUNT) ? MAX_TASKS : SLOT_COUNT;
    localparam int CNT_W = $clog2(NCELL + 1);
    localparam logic [SLOT_W:0] NCELL_L = (SLOT_W + 1)'(NCELL);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [TIME_W-1:0] r_now, n_now;
    t_result           r_res, n_res;
    logic              r_m_valid, n_m_valid;
    t_result           r_m_data, n_m_data;

    t_op               w_op;
    logic [SLOT_W-1:0] w_slot;
    logic [TIME_W-1:0] w_now;
    logic [PRIO_W-1:0] w_prio;
    logic [TIME_W-1:0] w_period;
    logic [RUNS_W-1:0] w_runs;
    logic              w_in_range;
    logic              w_accept;
    logic              w_out_free;
    logic              w_scan_end;
    logic              w_res_done;
    t_cell_stat        w_tgt;
    t_result           w_res_new;
    t_cmd              w_cmd;
    t_scan             w_last;
    t_scan             w_scan [NCELL+1];
    t_cell_stat        w_stat [NCELL];
    logic [NCELL-1:0]      w_rank0;
    logic [SLOT_COUNT-1:0] w_live_pad;

    // Unpack the request
    assign w_op     = t_op'(i_s_axis_tuser);
    assign w_slot   = i_s_axis_tdata[2:0];
    assign w_now    = i_s_axis_tdata[34:3];
    assign w_prio   = i_s_axis_tdata[42:35];
    assign w_period = i_s_axis_tdata[74:43];
    assign w_runs   = i_s_axis_tdata[90:75];

    assign w_in_range = ({1'b0, w_slot} < NCELL_L);
    assign o_s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_m_valid || i_m_axis_tready;
    assign w_scan_end = (r_state == S_SCAN) && (r_cnt == CNT_W'(NCELL));
    assign w_last     = w_scan[NCELL];

    // Pick the addressed slot's live flag and rank
    always_comb begin
        w_tgt = '0;
        for (int i = 0; i < NCELL; i++) begin
            if (w_slot == SLOT_W'(i)) begin
                w_tgt = w_stat[i];
            end
        end
    end

    // Build the command broadcast to all cells
    always_comb begin
        w_cmd          = '0;
        w_cmd.add      = w_accept && (w_op == OP_ADD) && w_in_range;
        w_cmd.rem      = w_accept && (w_op == OP_REMOVE) && w_in_range && w_tgt.live;
        w_cmd.commit   = w_scan_end && w_last.found;
        w_cmd.slot     = (r_state == S_SCAN) ? w_last.idx : w_slot;
        w_cmd.tgt_live = w_tgt.live;
        w_cmd.tgt_rank = w_tgt.rank;
        w_cmd.now      = (r_state == S_SCAN) ? r_now : w_now;
        w_cmd.prio     = w_prio;
        w_cmd.period   = w_period;
        w_cmd.runs     = w_runs;
    end

    // Form the result of the finishing request
    always_comb begin
        w_res_new = '0;
        if (r_state == S_SCAN) begin
            w_res_new.hit    = w_last.found;
            w_res_new.chosen = w_last.found ? w_last.idx : r_slot;
            w_res_new.score  = w_last.found ? w_last.score : '0;
        end else begin
            w_res_new.chosen = w_slot;
            unique case (w_op)
                OP_ADD:    w_res_new.hit = w_in_range;
                OP_REMOVE: w_res_new.hit = w_in_range && w_tgt.live;
                OP_YIELD:  w_res_new.hit = 1'b0;
                OP_NOP:    w_res_new.hit = 1'b0;
                default:   w_res_new.hit = 1'b0;
            endcase
        end
        w_res_done = (w_accept && (w_op != OP_YIELD)) || w_scan_end;
    end

    // Chain of slot cells; the sweep enters empty at cell 0
    assign w_scan[0] = '0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        apsel_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_scan  (w_scan[g]),
            .o_scan  (w_scan[g+1]),
            .o_stat  (w_stat[g])
        );
        assign w_rank0[g] = w_stat[g].live && (w_stat[g].rank == '0);
    end

    always_comb begin
        w_live_pad = '0;
        for (int i = 0; i < NCELL; i++) begin
            w_live_pad[i] = w_stat[i].live;
        end
    end

    // Sequence requests and steer results into the output register
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_slot    = r_slot;
        n_now     = r_now;
        n_res     = w_res_done ? w_res_new : r_res;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_m_data  = r_m_data;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_slot = w_slot;
                    n_now  = w_now;
                    if (w_op == OP_YIELD) begin
                        n_state = S_SCAN;
                        n_cnt   = '0;
                    end else if (!w_out_free) begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = w_out_free ? S_IDLE : S_HOLD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state   = S_IDLE;
                    n_m_valid = 1'b1;
                    n_m_data  = r_res;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (w_res_done && w_out_free) begin
            n_m_valid = 1'b1;
            n_m_data  = w_res_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_slot    <= n_slot;
            r_now     <= n_now;
            r_res     <= n_res;
            r_m_valid <= n_m_valid;
            r_m_data  <= n_m_data;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {4'b0, r_m_data};

    // Live ranks form 0..L-1, so at most one live slot is the newest
    `AST_IMP(a_one_newest, i_clk, i_rst_n, 1'b1, $onehot0(w_rank0), "two newest slots")
    // An add in range leaves the slot live
    `AST_NXT(a_add_live, i_clk, i_rst_n, w_cmd.add, w_live_pad[r_slot], "add left slot free")
    // A remove that hits leaves the slot free
    `AST_NXT(a_rem_free, i_clk, i_rst_n, w_cmd.rem, !w_live_pad[r_slot], "remove left slot live")

endmodule

### design/apsel_cell.sv
// One task slot: stored task fields, age rank, and one step of the yield sweep.
// Depends on apsel_pkg; instantiated in a chain by the top level.
module apsel_cell
    import apsel_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_scan      i_scan,
    output t_scan      o_scan,
    output t_cell_stat o_stat
);

    logic              r_live, n_live;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic [PRIO_W-1:0] r_prio, n_prio;
    logic [TIME_W-1:0] r_period, n_period;
    logic [RUNS_W-1:0] r_runs, n_runs;
    logic [TIME_W-1:0] r_due, n_due;
    t_scan             r_scan, n_scan;

    logic                 w_sel;
    logic [ELAPSED_W-1:0] w_el;
    logic [PRIO_W-1:0]    w_score;
    logic                 w_elig;
    logic                 w_take;

    // Score this slot against the incoming best candidate
    always_comb begin
        w_sel   = (i_cmd.slot == SLOT_W'(IDX));
        w_el    = i_cmd.now[ELAPSED_W-1:0] - r_due[ELAPSED_W-1:0];
        w_score = r_prio + w_el[PRIO_W-1:0];
        w_elig  = r_live && (r_runs != '0) && !w_el[ELAPSED_W-1];
        w_take  = w_elig && (!i_scan.found || (w_score > i_scan.score) ||
                  ((w_score == i_scan.score) && (r_rank > i_scan.rank)));
        n_scan  = i_scan;
        if (w_take) begin
            n_scan.found = 1'b1;
            n_scan.idx   = SLOT_W'(IDX);
            n_scan.score = w_score;
            n_scan.rank  = r_rank;
        end
    end

    // Keep live flag and age rank consistent on add and remove
    always_comb begin
        n_live = r_live;
        n_rank = r_rank;
        priority if (i_cmd.add && w_sel) begin
            n_live = 1'b1;
            n_rank = '0;
        end else if (i_cmd.add && r_live &&
                     (!i_cmd.tgt_live || (r_rank < i_cmd.tgt_rank))) begin
            n_rank = r_rank + 1'b1;
        end else if (i_cmd.rem && w_sel) begin
            n_live = 1'b0;
        end else if (i_cmd.rem && r_live && (r_rank > i_cmd.tgt_rank)) begin
            n_rank = r_rank - 1'b1;
        end else begin
            // hold
        end
    end

    // Load task fields on add, reschedule on commit
    always_comb begin
        n_prio   = r_prio;
        n_period = r_period;
        n_runs   = r_runs;
        n_due    = r_due;
        priority if (i_cmd.add && w_sel) begin
            n_prio   = i_cmd.prio;
            n_period = i_cmd.period;
            n_runs   = i_cmd.runs;
            n_due    = i_cmd.now;
        end else if (i_cmd.commit && w_sel) begin
            n_due = i_cmd.now + r_period;
            if (!r_runs[RUNS_W-1] && (r_runs != '0)) begin
                n_runs = r_runs - 1'b1;
            end
        end else begin
            // hold
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_rank <= '0;
        end else begin
            r_live <= n_live;
            r_rank <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio   <= n_prio;
        r_period <= n_period;
        r_runs   <= n_runs;
        r_due    <= n_due;
        r_scan   <= n_scan;
    end

    assign o_scan      = r_scan;
    assign o_stat.live = r_live;
    assign o_stat.rank = r_rank;

endmodule
